// ===== rtl/ddalloc_pkg.sv =====
// Shared types and constants for the deadlock detecting allocator.
// No dependencies; every other file of the block depends on this package.
package ddalloc_pkg;

  localparam int THREADS   = 8;
  localparam int RESOURCES = 5;
  localparam int MAX_UNITS = 3;
  localparam int UNITS_W   = 2;
  localparam int TID_W     = 3;
  localparam int SP_W      = 4;
  localparam int SUM_W     = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RETRY   = 2'd2;
  localparam logic [1:0] OP_DETECT  = 2'd3;

  typedef logic [UNITS_W-1:0] units_t;
  typedef units_t [RESOURCES-1:0] res_row_t;
  typedef logic [THREADS-1:0] tmask_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic build_step;
    logic root_step;
    logic dfs_step;
    logic scan_step;
    logic free_victim;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_detect;
    logic build_done;
    logic root_done;
    logic root_pushed;
    logic dfs_last_pop;
    logic dfs_cycle;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/ddalloc_in_if.sv =====
// Input and output channels of the allocator: valid/ready handshake and one item each.
// Depends on ddalloc_pkg for field widths.
interface ddalloc_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         operation;
  logic [ddalloc_pkg::TID_W-1:0]      thread_id;
  logic [ddalloc_pkg::UNITS_W-1:0]    req_r0;
  logic [ddalloc_pkg::UNITS_W-1:0]    req_r1;
  logic [ddalloc_pkg::UNITS_W-1:0]    req_r2;
  logic [ddalloc_pkg::UNITS_W-1:0]    req_r3;
  logic [ddalloc_pkg::UNITS_W-1:0]    req_r4;

  modport source (output valid, operation, thread_id, req_r0, req_r1, req_r2, req_r3, req_r4,
                  input ready);
  modport sink (input valid, operation, thread_id, req_r0, req_r1, req_r2, req_r3, req_r4,
                output ready);
endinterface

interface ddalloc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               granted;
  logic                               deadlock_found;
  logic [ddalloc_pkg::TID_W-1:0]      victim_id;
  logic [3:0]                         cycle_length;

  modport source (output valid, granted, deadlock_found, victim_id, cycle_length,
                  input ready);
  modport sink (input valid, granted, deadlock_found, victim_id, cycle_length,
                output ready);
endinterface

// ===== rtl/ddalloc_dp.sv =====
// Datapath of the allocator: pools, holdings, requests, wait-for graph,
// search stack and the result register. Depends on ddalloc_pkg.
module ddalloc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ddalloc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddalloc_pkg::UNITS_W-1:0]  cfg_data,
  input  ddalloc_pkg::cmd_t                cmd,
  output ddalloc_pkg::stat_t               stat,
  ddalloc_in_if.sink                       in_ch,
  ddalloc_out_if.source                    out_ch
);
  import ddalloc_pkg::*;

  units_t   avail [RESOURCES];
  res_row_t held [THREADS];
  res_row_t pending [THREADS];
  tmask_t   wait_flag;
  tmask_t   edge_row [THREADS];
  tmask_t   visited;
  tmask_t   onstack;
  logic [TID_W-1:0] stack [THREADS];
  logic [SP_W-1:0]  cursor [THREADS];
  logic [SP_W-1:0]  sp;
  logic [SP_W-1:0]  root;
  logic [TID_W-1:0] build_idx;
  logic [SP_W-1:0]  scan_k;
  logic [SUM_W-1:0] best_sum;

  logic [1:0]       op_q;
  logic [TID_W-1:0] tid_q;
  res_row_t         req_q;

  logic             res_granted;
  logic             res_found;
  logic [TID_W-1:0] res_victim;
  logic [3:0]       res_len;

  logic             out_valid;
  logic             out_granted;
  logic             out_found;
  logic [TID_W-1:0] out_victim;
  logic [3:0]       out_len;

  tmask_t           hold_mask [RESOURCES];
  tmask_t           build_row;
  res_row_t         sel_req;
  logic             req_fits;
  logic [TID_W-1:0] top_idx;
  logic [TID_W-1:0] top_u;
  logic [SP_W-1:0]  top_v;
  logic             edge_hit;
  logic [SP_W-1:0]  match_s;
  logic [TID_W-1:0] give_tid;
  logic [TID_W-1:0] scan_t;
  logic [SUM_W-1:0] scan_sum;

  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      for (int h = 0; h < THREADS; h++) begin
        hold_mask[r][h] = (held[h][r] != '0);
      end
    end
    build_row = '0;
    for (int r = 0; r < RESOURCES; r++) begin
      if (pending[build_idx][r] != '0) begin
        build_row = build_row | hold_mask[r];
      end
    end
    if (!wait_flag[build_idx]) begin
      build_row = '0;
    end
  end

  always_comb begin
    sel_req  = (op_q == OP_RETRY) ? pending[tid_q] : req_q;
    req_fits = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      if (sel_req[r] > avail[r]) begin
        req_fits = 1'b0;
      end
    end
  end

  always_comb begin
    top_idx  = TID_W'(sp - SP_W'(1));
    top_u    = stack[top_idx];
    top_v    = cursor[top_idx];
    edge_hit = (top_v < SP_W'(THREADS)) && edge_row[top_u][top_v[TID_W-1:0]];
    match_s  = '0;
    for (int s = 0; s < THREADS; s++) begin
      if ((SP_W'(s) < sp) && (stack[s] == top_v[TID_W-1:0])) begin
        match_s = SP_W'(s);
      end
    end
    scan_t   = stack[scan_k[TID_W-1:0]];
    scan_sum = '0;
    for (int r = 0; r < RESOURCES; r++) begin
      scan_sum = scan_sum + SUM_W'(held[scan_t][r]);
    end
    give_tid = cmd.free_victim ? res_victim : tid_q;
  end

  always_comb begin
    stat.is_detect    = (op_q == OP_DETECT);
    stat.build_done   = (build_idx == TID_W'(THREADS - 1));
    stat.root_done    = (root == SP_W'(THREADS));
    stat.root_pushed  = (root < SP_W'(THREADS)) && wait_flag[root[TID_W-1:0]] &&
                        !visited[root[TID_W-1:0]];
    stat.dfs_last_pop = (top_v == SP_W'(THREADS)) && (sp == SP_W'(1));
    stat.dfs_cycle    = edge_hit && visited[top_v[TID_W-1:0]] && onstack[top_v[TID_W-1:0]];
    stat.scan_done    = (scan_k == sp);
    stat.out_free     = !out_valid || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= in_ch.operation;
      tid_q    <= in_ch.thread_id;
      req_q[0] <= in_ch.req_r0;
      req_q[1] <= in_ch.req_r1;
      req_q[2] <= in_ch.req_r2;
      req_q[3] <= in_ch.req_r3;
      req_q[4] <= in_ch.req_r4;
    end
    if (cmd.build_step) begin
      edge_row[build_idx] <= build_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < RESOURCES; r++) begin
        avail[r] <= UNITS_W'(MAX_UNITS);
      end
      for (int t = 0; t < THREADS; t++) begin
        held[t]    <= '0;
        pending[t] <= '0;
      end
      wait_flag   <= '0;
      visited     <= '0;
      onstack     <= '0;
      sp          <= '0;
      root        <= '0;
      build_idx   <= '0;
      scan_k      <= '0;
      best_sum    <= '0;
      res_granted <= 1'b0;
      res_found   <= 1'b0;
      res_victim  <= '0;
      res_len     <= '0;
    end else begin
      if (cfg_we && (cfg_index < CFG_IDX_W'(RESOURCES))) begin
        avail[cfg_index] <= cfg_data;
      end
      if (cmd.load) begin
        visited     <= '0;
        onstack     <= '0;
        sp          <= '0;
        root        <= '0;
        build_idx   <= '0;
        res_granted <= 1'b0;
        res_found   <= 1'b0;
        res_victim  <= '0;
        res_len     <= '0;
      end
      if (cmd.exec) begin
        case (op_q)
          OP_REQUEST, OP_RETRY: begin
            if (req_fits && (op_q == OP_REQUEST || wait_flag[tid_q])) begin
              for (int r = 0; r < RESOURCES; r++) begin
                avail[r] <= avail[r] - sel_req[r];
                if ({1'b0, held[tid_q][r]} + {1'b0, sel_req[r]} > (UNITS_W+1)'(MAX_UNITS)) begin
                  held[tid_q][r] <= UNITS_W'(MAX_UNITS);
                end else begin
                  held[tid_q][r] <= held[tid_q][r] + sel_req[r];
                end
              end
              wait_flag[tid_q] <= 1'b0;
              pending[tid_q]   <= '0;
              res_granted      <= 1'b1;
            end else if (op_q == OP_REQUEST) begin
              pending[tid_q]   <= req_q;
              wait_flag[tid_q] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if ((cmd.exec && op_q == OP_RELEASE) || cmd.free_victim) begin
        for (int r = 0; r < RESOURCES; r++) begin
          if ({1'b0, avail[r]} + {1'b0, held[give_tid][r]} > (UNITS_W+1)'(MAX_UNITS)) begin
            avail[r] <= UNITS_W'(MAX_UNITS);
          end else begin
            avail[r] <= avail[r] + held[give_tid][r];
          end
        end
        held[give_tid] <= '0;
      end
      if (cmd.free_victim) begin
        wait_flag[res_victim] <= 1'b0;
        pending[res_victim]   <= '0;
        res_found             <= 1'b1;
      end
      if (cmd.build_step) begin
        build_idx <= build_idx + TID_W'(1);
      end
      if (cmd.root_step && !stat.root_done) begin
        if (stat.root_pushed) begin
          visited[root[TID_W-1:0]] <= 1'b1;
          onstack[root[TID_W-1:0]] <= 1'b1;
          stack[0]  <= root[TID_W-1:0];
          cursor[0] <= '0;
          sp        <= SP_W'(1);
        end else begin
          root <= root + SP_W'(1);
        end
      end
      if (cmd.dfs_step) begin
        if (top_v == SP_W'(THREADS)) begin
          onstack[top_u] <= 1'b0;
          sp             <= sp - SP_W'(1);
          if (sp == SP_W'(1)) begin
            root <= root + SP_W'(1);
          end
        end else begin
          cursor[top_idx] <= top_v + SP_W'(1);
          if (edge_hit && !visited[top_v[TID_W-1:0]]) begin
            if (sp < SP_W'(THREADS)) begin
              visited[top_v[TID_W-1:0]] <= 1'b1;
              onstack[top_v[TID_W-1:0]] <= 1'b1;
              stack[sp[TID_W-1:0]]      <= top_v[TID_W-1:0];
              cursor[sp[TID_W-1:0]]     <= '0;
              sp                        <= sp + SP_W'(1);
            end
          end else if (stat.dfs_cycle) begin
            scan_k  <= match_s;
            res_len <= sp - match_s;
          end
        end
      end
      if (cmd.scan_step) begin
        if ((scan_k == sp - SP_W'(res_len)) || (scan_sum < best_sum)) begin
          best_sum   <= scan_sum;
          res_victim <= scan_t;
        end
        scan_k <= scan_k + SP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_granted <= res_granted;
      out_found   <= res_found;
      out_victim  <= res_victim;
      out_len     <= res_len;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.granted        = out_granted;
  assign out_ch.deadlock_found = out_found;
  assign out_ch.victim_id      = out_victim;
  assign out_ch.cycle_length   = out_len;

`ifndef ASSERT_OFF
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(THREADS)) else $error("search stack overflow");
  a_onstack_visited: assert property (@(posedge clk) disable iff (rst)
    (onstack & ~visited) == '0) else $error("stacked thread not visited");
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && res_found |-> res_len != '0) else $error("deadlock without cycle");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free) else $error("result overwritten");
`endif

endmodule

// ===== rtl/ddalloc_ctrl.sv =====
// Controller of the allocator: sequences execute, graph build, search,
// victim scan and result hand-off. Depends on ddalloc_pkg.
module ddalloc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ddalloc_pkg::stat_t stat,
  output ddalloc_pkg::cmd_t  cmd
);
  import ddalloc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_BUILD = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_DFS   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_FREE  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_detect) begin
          state_next = S_BUILD;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_BUILD: begin
        cmd.build_step = 1'b1;
        if (stat.build_done) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (stat.root_done) begin
          state_next = S_DONE;
        end else begin
          cmd.root_step = 1'b1;
          if (stat.root_pushed) begin
            state_next = S_DFS;
          end
        end
      end
      S_DFS: begin
        cmd.dfs_step = 1'b1;
        if (stat.dfs_cycle) begin
          state_next = S_SCAN;
        end else if (stat.dfs_last_pop) begin
          state_next = S_ROOT;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_FREE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FREE: begin
        cmd.free_victim = 1'b1;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_EXEC) else $error("load did not start work");
  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == S_IDLE) else $error("emit without return to idle");
  a_scan_after_cycle: assert property (@(posedge clk) disable iff (rst)
    state == S_DFS && stat.dfs_cycle |=> state == S_SCAN) else $error("cycle not scanned");
`endif

endmodule

// ===== rtl/deadlock_detect_allocator.sv =====
// Resource allocator for 8 threads and 5 resource types with wait-for
// deadlock detection and recovery. Built from ddalloc_ctrl and ddalloc_dp.
//
// Channels: in_ch carries one item (operation, thread_id, req_r0..req_r4);
// out_ch returns exactly one result item (granted, deadlock_found,
// victim_id, cycle_length) for each item. Both use valid/ready.
// The configuration port writes cfg_data into the available count of
// resource cfg_index; indexes past the last resource are ignored.
// Write it only while the block is idle.
// A request, release or retry is executed and its result then handed to
// the output register. A detect builds the wait-for graph one thread at a
// time, examines the roots in order and walks depth-first from each root
// that waits and is not yet visited; when a cycle is found, it scans the
// cycle members for the one holding the fewest units, frees that victim
// and reports it with the cycle length.
// One item is worked on at a time; the next is accepted once the current
// result sits in the output register, even while the receiver stalls.
// A stalled receiver holds the result; a finished item then waits in the
// controller until the output register is free.
// Reset clears all holdings, requests and wait flags and sets every pool
// to three units.
module deadlock_detect_allocator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ddalloc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddalloc_pkg::UNITS_W-1:0]    cfg_data,
  ddalloc_in_if.sink                         in_ch,
  ddalloc_out_if.source                      out_ch
);
  import ddalloc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ddalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ddalloc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule
